// ===== sv/assert_macros.svh =====
// assertion macros shared by the queue modules
// assumes a clock named clk and an active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// trigger in one cycle implies consequence in the next
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== sv/npcq_pkg.sv =====
// types, codes and ordering function for the priority channel queue
// no dependencies
`default_nettype none

package npcq_pkg;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] arrive;
    logic [15:0] dur;
    logic [9:0]  seq;
  } entry_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

  // true when waiting entry w is served before newcomer n
  function automatic logic stays_ahead(input entry_t w, input entry_t n);
    logic res;
    if (w.prio != n.prio) begin
      res = w.prio < n.prio;
    end else if (w.arrive != n.arrive) begin
      res = w.arrive < n.arrive;
    end else if (w.dur != n.dur) begin
      res = w.dur < n.dur;
    end else begin
      res = w.seq < n.seq;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/npcq_ctrl.sv =====
// sequencing state machine for the priority channel queue
// depends on npcq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module npcq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output npcq_pkg::ctl_t     ctl
);
  import npcq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_HOLD);
  assign ctl.load  = (state == S_IDLE) && in_valid;
  assign ctl.exec  = (state == S_EXEC);

  // a loaded item is always worked on in the following cycle
  `ASSERT_NEXT(a_load_then_exec, ctl.load, ctl.exec, "load not followed by exec")
  // every result shown comes from an update just before it
  `ASSERT_CLK(a_result_after_exec, $rose(out_valid) |-> $past(ctl.exec), "result without exec")

endmodule

`default_nettype wire

// ===== sv/npcq_dp.sv =====
// sorted entry row, insert and pop shifting, result registers
// depends on npcq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module npcq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire npcq_pkg::ctl_t ctl,
  input  wire logic          command,
  input  wire logic [7:0]    flow_id,
  input  wire logic [7:0]    flow_priority,
  input  wire logic [15:0]   arrival_tenths,
  input  wire logic [15:0]   duration_tenths,
  input  wire logic [9:0]    sequence_number,
  output logic               grant,
  output logic               head_valid,
  output logic [7:0]         head_flow_id,
  output logic [4:0]         waiting_count,
  output logic [1:0]         status
);
  import npcq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic           cmd;
  entry_t         item;
  entry_t         slot [QUEUE_DEPTH];
  logic [CW-1:0]  count;

  logic [QUEUE_DEPTH-1:0] keep;
  entry_t         slot_ins  [QUEUE_DEPTH];
  entry_t         slot_pop  [QUEUE_DEPTH];
  entry_t         slot_next [QUEUE_DEPTH];
  logic [CW-1:0]  count_next;
  logic           grant_next;
  logic [1:0]     status_next;
  logic [CW-1:0]  wait_n;
  logic [31:0]    wait_wide;

  // item register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd         <= command;
      item.id     <= flow_id;
      item.prio   <= flow_priority;
      item.arrive <= arrival_tenths;
      item.dur    <= duration_tenths;
      item.seq    <= sequence_number;
    end
  end

  // per-slot compare: head always stays, waiting slots stay while strictly ahead
  always_comb begin
    keep[0] = 1'b1;
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      keep[k] = (CW'(k) < count) && stays_ahead(slot[k], item);
    end
  end

  always_comb begin
    slot_ins[0] = slot[0];
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      if (keep[k]) begin
        slot_ins[k] = slot[k];
      end else if (keep[k-1]) begin
        slot_ins[k] = item;
      end else begin
        slot_ins[k] = slot[k-1];
      end
    end
    for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
      slot_pop[k] = slot[k+1];
    end
    slot_pop[QUEUE_DEPTH-1] = slot[QUEUE_DEPTH-1];
  end

  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      slot_next[k] = slot[k];
    end
    count_next  = count;
    grant_next  = 1'b0;
    status_next = STATUS_OK;
    case (cmd)
      CMD_REQUEST: begin
        if (count == CW'(QUEUE_DEPTH)) begin
          status_next = STATUS_FULL;
        end else if (count == '0) begin
          slot_next[0] = item;
          count_next   = CW'(1);
          grant_next   = 1'b1;
        end else begin
          for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slot_next[k] = slot_ins[k];
          end
          count_next = count + CW'(1);
        end
      end
      CMD_RELEASE: begin
        if (count == '0) begin
          status_next = STATUS_EMPTY;
        end else begin
          for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slot_next[k] = slot_pop[k];
          end
          count_next = count - CW'(1);
          grant_next = (count != CW'(1));
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  assign wait_n    = count_next - CW'(1);
  assign wait_wide = 32'(wait_n);

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        slot[k] <= slot_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      grant         <= 1'b0;
      head_valid    <= 1'b0;
      head_flow_id  <= '0;
      waiting_count <= '0;
      status        <= STATUS_OK;
    end else if (ctl.exec) begin
      count         <= count_next;
      grant         <= grant_next;
      head_valid    <= (count_next != '0);
      head_flow_id  <= (count_next != '0) ? slot_next[0].id : 8'd0;
      waiting_count <= (count_next != '0) ? wait_wide[4:0] : 5'd0;
      status        <= status_next;
    end
  end

  `ASSERT_CLK(a_count_bound, count <= CW'(QUEUE_DEPTH), "entry count beyond depth")
  `ASSERT_NEXT(a_head_matches_count, ctl.exec, head_valid == (count != '0), "head flag off count")
  `ASSERT_CLK(a_grant_has_head, grant |-> head_valid, "grant without head")

endmodule

`default_nettype wire

// ===== sv/nonpreemptive_priority_channel_queue.sv =====
// Non-preemptive priority arbiter for one shared channel. A request (command 0) takes the idle
// channel at once with grant set; otherwise it joins a sorted waiting line behind the head,
// ordered by lower priority value, then earlier arrival, shorter duration, lower sequence
// number. A release (command 1) pops the head and grants the next entry if one waits. A
// request into a full store reports status 1, a release with nothing queued reports status 2;
// neither changes state. Each item gives one result: the item is registered at acceptance, the
// parallel compare and shift of the entry row run in the execute state, and out_valid rises
// when the controller enters its hold state. The next item is taken in the cycle after the
// result has been taken, so no new item is accepted while one is in flight. QUEUE_DEPTH sets
// the number of entry slots including the head. Depends on npcq_pkg, npcq_ctrl and npcq_dp.
`default_nettype none

module nonpreemptive_priority_channel_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [7:0]  flow_id,
  input  wire logic [7:0]  flow_priority,
  input  wire logic [15:0] arrival_tenths,
  input  wire logic [15:0] duration_tenths,
  input  wire logic [9:0]  sequence_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             grant,
  output logic             head_valid,
  output logic [7:0]       head_flow_id,
  output logic [4:0]       waiting_count,
  output logic [1:0]       status
);
  import npcq_pkg::*;

  ctl_t ctl;

  npcq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  npcq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .command         (command),
    .flow_id         (flow_id),
    .flow_priority   (flow_priority),
    .arrival_tenths  (arrival_tenths),
    .duration_tenths (duration_tenths),
    .sequence_number (sequence_number),
    .grant           (grant),
    .head_valid      (head_valid),
    .head_flow_id    (head_flow_id),
    .waiting_count   (waiting_count),
    .status          (status)
  );

endmodule

`default_nettype wire
